FILE: design/kfr_pkg.sv
// ----------------------------------------------------------------------------
// kfr_pkg: shared types and constants of the keyframe reduction filter
// Field widths, blend format and the command/status bundles between the
// controller and the datapath.
// ----------------------------------------------------------------------------
package kfr_pkg;

  localparam int ValueWidth = 32;
  localparam int TimeWidth  = 32;
  localparam int BlendBits  = 16;
  localparam int TolWidth   = 32;
  localparam int AxisCount  = 3;
  localparam int AxisIdxW   = 2;

  typedef logic signed [ValueWidth-1:0] value_t;
  typedef logic [TimeWidth-1:0]         time_t;
  typedef logic [BlendBits:0]           blend_t;

  // controller to datapath
  typedef struct packed {
    logic load_in;      // capture accepted input key
    logic div_start;    // begin blend division
    logic err_start;    // begin error accumulation
    logic shift_keys;   // older <= middle, middle <= new
    logic set_middle;   // middle <= new
    logic set_older;    // older <= new
    logic sel_middle;   // result mux: 1 middle key, 0 new key
  } kfr_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic div_done;
    logic err_done;
    logic kept;
  } kfr_sts_t;

endpackage

FILE: design/kfr_datapath.sv
// ----------------------------------------------------------------------------
// kfr_datapath: key window, serial blend divider and error accumulator
// One restoring division step per cycle, then one axis at a time through the
// offset, blend product, error square and overflow-flagged sum.
// ----------------------------------------------------------------------------
module kfr_datapath (
  input  logic               clk,
  input  logic               rst,
  input  kfr_pkg::kfr_cmd_t  cmd,
  output kfr_pkg::kfr_sts_t  sts,
  input  logic [31:0]        tolerance,
  input  kfr_pkg::time_t     in_time,
  input  kfr_pkg::value_t    in_x,
  input  kfr_pkg::value_t    in_y,
  input  kfr_pkg::value_t    in_z,
  output kfr_pkg::time_t     res_time,
  output kfr_pkg::value_t    res_x,
  output kfr_pkg::value_t    res_y,
  output kfr_pkg::value_t    res_z
);
  import kfr_pkg::*;

  localparam int DiffW = TimeWidth + 1;
  localparam int StepW = $clog2(BlendBits + 1);

  typedef enum logic [2:0] {E_IDLE, E_OFF, E_ERR, E_SQ, E_ACC, E_CMP} err_st_t;

  time_t  older_time, middle_time, new_time;
  value_t older_vals [AxisCount];
  value_t middle_vals[AxisCount];
  value_t new_vals   [AxisCount];

  // divider
  logic [DiffW-1:0]   div_rem, div_den;
  logic [BlendBits-1:0] div_q;
  logic [StepW-1:0]   div_cnt;
  logic               div_busy, div_done;
  blend_t             blend;
  logic signed [DiffW:0] num_s, den_s;
  logic [DiffW:0]     rem_sh;

  // error unit
  err_st_t                 est;
  logic [AxisIdxW-1:0]     axis;
  logic signed [ValueWidth:0]   dnew, dmid;
  logic signed [ValueWidth+BlendBits+1:0] prod;
  logic signed [ValueWidth+1:0] off, err;
  logic [ValueWidth+1:0]   mag;
  logic [63:0]             sq, sum;
  logic                    over, kept, err_done;
  logic [63:0]             tol2;

  // the division starts on the accepting edge, so the new time comes from the port
  assign num_s = $signed({2'b00, middle_time}) - $signed({2'b00, older_time});
  assign den_s = $signed({2'b00, in_time})     - $signed({2'b00, older_time});
  assign rem_sh = {div_rem, 1'b0};

  // key window
  always_ff @(posedge clk) begin
    if (cmd.load_in) begin
      new_time    <= in_time;
      new_vals[0] <= in_x;
      new_vals[1] <= in_y;
      new_vals[2] <= in_z;
    end
    if (cmd.shift_keys) begin
      older_time  <= middle_time;
      older_vals  <= middle_vals;
      middle_time <= new_time;
      middle_vals <= new_vals;
    end
    if (cmd.set_middle) begin
      middle_time <= new_time;
      middle_vals <= new_vals;
    end
    if (cmd.set_older) begin
      older_time <= new_time;
      older_vals <= new_vals;
    end
  end

  // blend divider, one quotient bit per cycle
  always_ff @(posedge clk) begin
    if (rst) begin
      div_busy <= 1'b0;
      div_done <= 1'b0;
    end else begin
      div_done <= 1'b0;
      if (cmd.div_start) begin
        div_rem <= num_s[DiffW-1:0];
        div_den <= den_s[DiffW-1:0];
        div_q   <= '0;
        div_cnt <= '0;
        if (den_s <= 0 || num_s <= 0) begin
          blend    <= '0;
          div_done <= 1'b1;
        end else if (num_s >= den_s) begin
          blend    <= blend_t'(1) << BlendBits;
          div_done <= 1'b1;
        end else begin
          div_busy <= 1'b1;
        end
      end else if (div_busy) begin
        if (rem_sh >= {1'b0, div_den}) begin
          div_rem <= DiffW'(rem_sh - {1'b0, div_den});
          div_q   <= {div_q[BlendBits-2:0], 1'b1};
        end else begin
          div_rem <= rem_sh[DiffW-1:0];
          div_q   <= {div_q[BlendBits-2:0], 1'b0};
        end
        div_cnt <= div_cnt + StepW'(1);
        if (div_cnt == StepW'(BlendBits - 1)) begin
          div_busy <= 1'b0;
          div_done <= 1'b1;
          blend    <= {1'b0, div_q[BlendBits-2:0],
                       (rem_sh >= {1'b0, div_den})};
        end
      end
    end
  end

  // offset, error and magnitude of the current axis
  always_comb begin
    // floor(d * blend / 2^16) via arithmetic shift
    off = (ValueWidth+2)'(prod >>> BlendBits);
    err = (ValueWidth+2)'(dmid) - off;
    mag = err[ValueWidth+1] ? (ValueWidth+2)'(-err) : err;
  end

  // error accumulation, one axis at a time
  always_ff @(posedge clk) begin
    if (rst) begin
      est      <= E_IDLE;
      err_done <= 1'b0;
    end else begin
      err_done <= 1'b0;
      unique case (est)
        E_IDLE: if (cmd.err_start) begin
          axis <= '0;
          sum  <= '0;
          over <= 1'b0;
          tol2 <= 64'(tolerance) * 64'(tolerance);
          est  <= E_OFF;
        end
        E_OFF: begin
          dnew <= (ValueWidth+1)'(new_vals[axis]) - (ValueWidth+1)'(older_vals[axis]);
          dmid <= (ValueWidth+1)'(middle_vals[axis]) - (ValueWidth+1)'(older_vals[axis]);
          est  <= E_ERR;
        end
        E_ERR: begin
          prod <= dnew * $signed({1'b0, blend});
          est  <= E_SQ;
        end
        E_SQ: begin
          if (|mag[ValueWidth+1:32]) over <= 1'b1;
          sq  <= 64'(mag[31:0]) * 64'(mag[31:0]);
          est <= E_ACC;
        end
        E_ACC: begin
          if (sum > ~sq) over <= 1'b1;
          sum <= sum + sq;
          if (axis == AxisIdxW'(AxisCount - 1)) begin
            est <= E_CMP;
          end else begin
            axis <= axis + AxisIdxW'(1);
            est  <= E_OFF;
          end
        end
        E_CMP: begin
          kept     <= over || (sum > tol2);
          err_done <= 1'b1;
          est      <= E_IDLE;
        end
        default: est <= E_IDLE;
      endcase
    end
  end

  assign sts.div_done = div_done;
  assign sts.err_done = err_done;
  assign sts.kept     = kept;

  // result selection
  assign res_time = cmd.sel_middle ? middle_time    : new_time;
  assign res_x    = cmd.sel_middle ? middle_vals[0] : new_vals[0];
  assign res_y    = cmd.sel_middle ? middle_vals[1] : new_vals[1];
  assign res_z    = cmd.sel_middle ? middle_vals[2] : new_vals[2];

  a_done_excl: assert property (@(posedge clk) disable iff (rst)
    !(div_done && div_busy)) else $error("divider done while busy");
  a_err_once: assert property (@(posedge clk) disable iff (rst)
    err_done |=> !err_done) else $error("error unit done twice");
  a_blend_rng: assert property (@(posedge clk) disable iff (rst)
    $rose(div_done) |-> (blend <= (blend_t'(1) << BlendBits)))
    else $error("blend out of range");

endmodule

FILE: design/kfr_ctrl.sv
// ----------------------------------------------------------------------------
// kfr_ctrl: sequencer of the keyframe reduction filter
// Accepts a key, runs the blend and error units when a middle key is held,
// and hands up to two result transactions to the output register.
// ----------------------------------------------------------------------------
module kfr_ctrl (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic               in_last,
  output logic               out_valid,
  input  logic               out_ready,
  output logic               out_last,
  output logic               out_load,
  output kfr_pkg::kfr_cmd_t  cmd,
  input  kfr_pkg::kfr_sts_t  sts
);
  import kfr_pkg::*;

  typedef enum logic [2:0] {S_IDLE, S_DIV, S_ERR, S_MID, S_NEW, S_WAIT} state_t;

  state_t     state;
  logic [1:0] keys_held;
  logic       last_r, emit_new;
  logic       out_free;

  assign out_free = !out_valid || out_ready;
  assign in_ready = (state == S_IDLE);

  always_comb begin
    cmd = '0;
    out_load = 1'b0;
    cmd.load_in   = in_valid && in_ready;
    cmd.div_start = (state == S_IDLE) && in_valid && keys_held[1];
    cmd.err_start = (state == S_DIV) && sts.div_done;
    cmd.sel_middle = (state == S_MID);
    if (state == S_MID && out_free) out_load = 1'b1;
    if (state == S_NEW && out_free) out_load = 1'b1;
    if (state == S_WAIT) begin
      cmd.set_older  = (keys_held == 2'd0) && !last_r;
      cmd.set_middle = (keys_held == 2'd1) && !last_r;
      cmd.shift_keys = keys_held[1] && !last_r;
    end
  end

  // state, key count and output valid
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      keys_held <= 2'd0;
      last_r    <= 1'b0;
      emit_new  <= 1'b0;
      out_valid <= 1'b0;
      out_last  <= 1'b0;
    end else begin
      if (out_valid && out_ready) out_valid <= 1'b0;
      if (out_load) out_valid <= 1'b1;
      unique case (state)
        S_IDLE: if (in_valid) begin
          last_r <= in_last;
          if (keys_held[1]) begin
            state <= S_DIV;
          end else begin
            emit_new <= (keys_held == 2'd0) || in_last;
            state    <= ((keys_held == 2'd0) || in_last) ? S_NEW : S_WAIT;
          end
        end
        S_DIV: if (sts.div_done) state <= S_ERR;
        S_ERR: if (sts.err_done) begin
          emit_new <= last_r;
          state    <= sts.kept ? S_MID : (last_r ? S_NEW : S_WAIT);
        end
        S_MID: if (out_free) begin
          out_last <= 1'b0;
          state    <= emit_new ? S_NEW : S_WAIT;
        end
        S_NEW: if (out_free) begin
          out_last <= last_r;
          state    <= S_WAIT;
        end
        S_WAIT: begin
          if (last_r)                 keys_held <= 2'd0;
          else if (keys_held == 2'd0) keys_held <= 2'd1;
          else                        keys_held <= 2'd2;
          state <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  a_one_load: assert property (@(posedge clk) disable iff (rst)
    out_load |-> out_free) else $error("output overwritten");
  a_no_accept: assert property (@(posedge clk) disable iff (rst)
    (state != S_IDLE) |-> !cmd.load_in) else $error("accept while busy");
  a_held_rng: assert property (@(posedge clk) disable iff (rst)
    keys_held != 2'd3) else $error("bad key count");

endmodule

FILE: design/keyframe_reduction_filter_core.sv
// ----------------------------------------------------------------------------
// keyframe_reduction_filter_core: linear-error keyframe reduction
// Top level joining the sequencer, datapath and output register.
// ----------------------------------------------------------------------------
// One key is taken at a time: a key is not accepted until the sequencer is
// back in idle. A key with a middle key held passes the accept state, 16 steps
// of the serial blend divider, the three-axis error unit (offset, blend
// product, square and sum for each axis, one 32x32 square each) and the states
// that emit results and update the window. When the blend is fixed without
// division (equal or out-of-order times, or a middle key at or past the new
// time) the 16 divider steps drop out. Results pass through one output
// register; a stalled output holds the sequencer until taken.
module keyframe_reduction_filter_core (
  input  logic         clk,
  input  logic         rst,
  input  logic         cfg_we,
  input  logic [31:0]  cfg_wdata,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  input  logic [127:0] s_axis_tdata,   // key_time, val_x, val_y, val_z
  input  logic         s_axis_tlast,   // last_key
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  output logic [127:0] m_axis_tdata,   // out_time, out_x, out_y, out_z
  output logic         m_axis_tlast    // out_last
);
  import kfr_pkg::*;

  logic [31:0] tolerance;
  kfr_cmd_t    cmd;
  kfr_sts_t    sts;
  logic        out_load;
  time_t       res_time;
  value_t      res_x, res_y, res_z;

  // tolerance register
  always_ff @(posedge clk) begin
    if (rst) tolerance <= '0;
    else if (cfg_we) tolerance <= cfg_wdata;
  end

  kfr_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (s_axis_tvalid),
    .in_ready  (s_axis_tready),
    .in_last   (s_axis_tlast),
    .out_valid (m_axis_tvalid),
    .out_ready (m_axis_tready),
    .out_last  (m_axis_tlast),
    .out_load  (out_load),
    .cmd       (cmd),
    .sts       (sts)
  );

  kfr_datapath u_dp (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .sts       (sts),
    .tolerance (tolerance),
    .in_time   (s_axis_tdata[31:0]),
    .in_x      (s_axis_tdata[63:32]),
    .in_y      (s_axis_tdata[95:64]),
    .in_z      (s_axis_tdata[127:96]),
    .res_time  (res_time),
    .res_x     (res_x),
    .res_y     (res_y),
    .res_z     (res_z)
  );

  // output data register
  always_ff @(posedge clk) begin
    if (out_load) m_axis_tdata <= {res_z, res_y, res_x, res_time};
  end

endmodule
